// ===== rtl/core/lrupr_pkg.sv =====
package lrupr_pkg;

	// Frame store geometry
	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 8;
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W    = FRAME_W;
	localparam int CFG_W     = 4;
	localparam int FAULT_W   = 16;
	localparam int OUT_FRAME_W = 3;

	localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(FRAMES - 1);
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(3);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [FRAME_W-1:0]   fidx_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [FAULT_W-1:0]   fault_t;
	typedef logic [FRAMES-1:0]    fmask_t;

	// Outcome of one reference lookup
	typedef struct packed {
		logic  hit;
		fidx_t frame;
		logic  ev_valid;
		page_t ev_page;
	} decision_t;

endpackage

// ===== rtl/core/lrupr_lookup.sv =====
module lrupr_lookup (
	input  lrupr_pkg::page_t     page,
	input  lrupr_pkg::page_t     pages [lrupr_pkg::FRAMES],
	input  lrupr_pkg::fmask_t    valid,
	input  lrupr_pkg::rank_t     ranks [lrupr_pkg::FRAMES],
	input  lrupr_pkg::fmask_t    act,
	output lrupr_pkg::decision_t dec
);

	lrupr_pkg::fmask_t hit_vec;
	lrupr_pkg::fmask_t empty_vec;
	lrupr_pkg::fidx_t  hit_idx;
	lrupr_pkg::fidx_t  empty_idx;
	lrupr_pkg::fidx_t  victim_idx;
	lrupr_pkg::rank_t  best;

	// Parallel tag compare and empty-frame detect
	always_comb begin
		for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
			hit_vec[i]   = act[i] && valid[i] && (pages[i] == page);
			empty_vec[i] = act[i] && !valid[i];
		end
	end

	// Lowest-numbered hit and lowest-numbered empty frame
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = lrupr_pkg::FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = lrupr_pkg::FRAME_W'(i);
			if (empty_vec[i]) empty_idx = lrupr_pkg::FRAME_W'(i);
		end
	end

	// Oldest active frame; ties go to the lowest index
	always_comb begin
		best       = '0;
		victim_idx = '0;
		for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
			if (act[i] && (ranks[i] > best)) begin
				best       = ranks[i];
				victim_idx = lrupr_pkg::FRAME_W'(i);
			end
		end
	end

	// Hit, fill or evict
	always_comb begin
		dec = '0;
		if (|hit_vec) begin
			dec.hit   = 1'b1;
			dec.frame = hit_idx;
		end else if (|empty_vec) begin
			dec.frame = empty_idx;
		end else begin
			dec.frame    = victim_idx;
			dec.ev_valid = 1'b1;
			dec.ev_page  = pages[victim_idx];
		end
	end

endmodule

// ===== rtl/core/lrupr_state.sv =====
module lrupr_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  lrupr_pkg::page_t     page,
	input  lrupr_pkg::decision_t dec,
	input  lrupr_pkg::fmask_t    act,
	output lrupr_pkg::page_t     pages [lrupr_pkg::FRAMES],
	output lrupr_pkg::fmask_t    valid,
	output lrupr_pkg::rank_t     ranks [lrupr_pkg::FRAMES],
	output lrupr_pkg::fault_t    fault_next
);

	lrupr_pkg::page_t  pages_q [lrupr_pkg::FRAMES];
	lrupr_pkg::fmask_t valid_q;
	lrupr_pkg::rank_t  ranks_q [lrupr_pkg::FRAMES];
	lrupr_pkg::fault_t fault_q;
	lrupr_pkg::rank_t  old_rank;
	lrupr_pkg::rank_t  ranks_d [lrupr_pkg::FRAMES];

	assign pages = pages_q;
	assign valid = valid_q;
	assign ranks = ranks_q;

	// Saturating fault count, including the current miss
	assign fault_next = (!dec.hit && (fault_q != lrupr_pkg::FAULT_MAX)) ?
		fault_q + lrupr_pkg::FAULT_W'(1) : fault_q;

	// Touched frame goes to rank 0; younger active frames age by one
	always_comb begin
		old_rank = valid_q[dec.frame] ? ranks_q[dec.frame] : lrupr_pkg::RANK_MAX;
		for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
			ranks_d[i] = ranks_q[i];
			if (lrupr_pkg::FRAME_W'(i) == dec.frame) begin
				ranks_d[i] = '0;
			end else if (act[i] && valid_q[i] && (ranks_q[i] < old_rank) &&
					(ranks_q[i] < lrupr_pkg::RANK_MAX)) begin
				ranks_d[i] = ranks_q[i] + lrupr_pkg::RANK_W'(1);
			end
		end
	end

	// Frame table update on each committed reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fault_q <= '0;
			for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
				pages_q[i] <= '0;
				ranks_q[i] <= '0;
			end
		end else if (upd) begin
			valid_q[dec.frame] <= 1'b1;
			pages_q[dec.frame] <= page;
			fault_q            <= fault_next;
			ranks_q            <= ranks_d;
		end
	end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// A word accepted into the input register is presented on the outputs once it moves into the result register.
// Throughput: one reference per cycle while out_stall does not hold a result; lookup, rank update
// and result capture all complete between the input and output registers.
// Reset (arst_n low, asynchronous): all frames empty, ranks and fault count zero,
// frames_in_use back to 3, no word held in either register.
module lru_page_replacement (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lrupr_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lrupr_pkg::PAGE_BITS-1:0]    page,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [lrupr_pkg::OUT_FRAME_W-1:0]  frame,
	output logic                               evicted_valid,
	output logic [lrupr_pkg::PAGE_BITS-1:0]    evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]      fault_total
);

	logic [lrupr_pkg::CFG_W-1:0] frames_q;
	lrupr_pkg::fmask_t           act;
	logic                        valid_s1;
	lrupr_pkg::page_t            page_s1;
	logic                        out_free;
	logic                        advance;
	logic                        accept;
	logic                        out_valid_q;
	lrupr_pkg::decision_t        dec;
	lrupr_pkg::page_t            pages [lrupr_pkg::FRAMES];
	lrupr_pkg::fmask_t           fvalid;
	lrupr_pkg::rank_t            ranks [lrupr_pkg::FRAMES];
	lrupr_pkg::fault_t           fault_next;
	logic                        hit_q;
	logic [lrupr_pkg::OUT_FRAME_W-1:0] frame_q;
	logic                        ev_valid_q;
	lrupr_pkg::page_t            ev_page_q;
	lrupr_pkg::fault_t           fault_total_q;

	// Configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lrupr_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_q <= cfg_data;
		end
	end

	// Active frames: frame 0 always, others below the configured count
	always_comb begin
		for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
			act[i] = (i == 0) || (int'(frames_q) > i);
		end
	end

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) page_s1 <= page;
	end

	lrupr_lookup u_lookup (
		.page  (page_s1),
		.pages (pages),
		.valid (fvalid),
		.ranks (ranks),
		.act   (act),
		.dec   (dec)
	);

	lrupr_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (advance),
		.page       (page_s1),
		.dec        (dec),
		.act        (act),
		.pages      (pages),
		.valid      (fvalid),
		.ranks      (ranks),
		.fault_next (fault_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q         <= dec.hit;
			frame_q       <= lrupr_pkg::OUT_FRAME_W'(dec.frame);
			ev_valid_q    <= dec.ev_valid;
			ev_page_q     <= dec.ev_page;
			fault_total_q <= fault_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame         = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_total_q;

endmodule

// ===== rtl/core/lrupr_checker.sv =====
module lrupr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               hit,
	input logic                               evicted_valid,
	input logic [lrupr_pkg::PAGE_BITS-1:0]    evicted_page,
	input logic [lrupr_pkg::FAULT_W-1:0]      fault_total
);

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> !evicted_valid)
		else $error("eviction reported on a hit");

	// No eviction means a zero evicted page
	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted_valid) |-> (evicted_page == '0))
		else $error("evicted page nonzero without eviction");

	// Fault total never drops between back-to-back words
	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 out_valid |-> (fault_total >= $past(fault_total)))
		else $error("fault total decreased");

	// Input backs up only behind a stalled output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.hit           (hit),
	.evicted_valid (evicted_valid),
	.evicted_page  (evicted_page),
	.fault_total   (fault_total)
);
